/* rtl/nbst_pkg.sv */
// ----------------------------------------------------------------------------
// nbst_pkg
// Shared types and constants for the nearest box stack table.
// ----------------------------------------------------------------------------
package nbst_pkg;

  localparam int MaxBoxesDefault  = 256;
  localparam int CoordBitsDefault = 24;

  localparam int HeightBits = 20;
  localparam logic [HeightBits-1:0] HeightReset = 20'd38100;

  // z of a box that has left the stack: -100 m
  localparam logic signed [27:0] FarDownUm = -28'sd100000000;

  localparam logic signed [7:0] LevelMax = 8'sd127;
  localparam logic signed [7:0] LevelMin = -8'sd128;

  // register index decoded from paddr[2]
  localparam logic RegBoxHeight = 1'b0;

  typedef enum logic [2:0] {
    ActClear    = 3'd0,
    ActLoad     = 3'd1,
    ActSetPos   = 3'd2,
    ActMoveDown = 3'd3,
    ActNearest  = 3'd4
  } action_e;

endpackage

/* rtl/nearest_box_stack_table.sv */
// ----------------------------------------------------------------------------
// nearest_box_stack_table
// Table of stacked boxes with load, edit, move-down and nearest search.
// ----------------------------------------------------------------------------
// Usage: one word in (action, box_id, pos_x/y/z) on a valid/ready channel,
// one result word out (found, entry_id, new_level, now_visible,
// entry_count) on a valid/ready channel. box_height_um sits at APB address
// 0; write it only while the block is idle (the block does not enforce this).
// Entries live in a single memory with registered read data; every
// edit reads the entry, modifies it and writes it back.
// Steps per word, from acceptance to the raised out_valid_o:
//   clear, refused actions ..... respond
//   load ....................... eight-step level divider, respond
//   set position, move down .... read, modify/write, respond
//   nearest .................... scan of the held entries, one entry per
//                                cycle through the distance pipeline, then
//                                read, modify/write if found; respond
// A new word is taken in the cycle after the previous result is loaded
// into the output register; a stalled receiver holds the result there,
// and the next word's result waits until that register frees up. Reset
// empties the table (count to zero) and loads the default box height;
// memory contents need no clearing.
// ----------------------------------------------------------------------------
module nearest_box_stack_table import nbst_pkg::*; #(
  parameter int MAX_BOXES  = MaxBoxesDefault,
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   action_i,
  input  logic [7:0]                   box_id_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [7:0]                   entry_id_o,
  output logic signed [7:0]            new_level_o,
  output logic                         now_visible_o,
  output logic [8:0]                   entry_count_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int CB = COORD_BITS;
  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int ZW = (CB + 1 > 28) ? CB + 1 : 28;
  localparam int NW = ((CB > 21) ? CB : 21) + 3;
  localparam int EW = 2*CB + ZW + 9;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SCAN, S_RD, S_MOD, S_RESP
  } state_e;

  state_e               state_q;
  action_e              act_q;
  logic signed [CB-1:0] px_q, py_q, pz_q;
  logic [CW-1:0]        count_q;
  logic [IW-1:0]        tgt_q;
  logic                 res_hit_q, res_vis_q;
  logic signed [7:0]    res_lvl_q;
  logic [HeightBits-1:0] height_q;

  logic                 out_valid_q, found_q, vis_q;
  logic [7:0]           eid_q;
  logic signed [7:0]    lvl_q;
  logic [8:0]           ecount_q;

  logic                  in_acc, cfg_wr;
  logic [HeightBits-1:0] h_eff, hh;
  logic signed [ZW-1:0]  z_load;
  logic signed [NW-1:0]  div_n;
  logic                  div_start, div_done;
  logic signed [7:0]     div_lvl;
  logic                  scan_start, scan_done, scan_have;
  logic [IW-1:0]         scan_best, scan_addr;

  logic                  mem_we;
  logic [IW-1:0]         mem_waddr, mem_raddr;
  logic [EW-1:0]         mem_wdata, mem_rdata;

  logic [CB-1:0]         rd_x, rd_y;
  logic signed [7:0]     rd_lvl, md_lvl;
  logic                  rd_vis, md_vis;
  logic [26:0]           md_prod;
  logic signed [ZW-1:0]  md_z;
  logic                  cap_ok, id_ok;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign cfg_wr     = psel && penable && pwrite && (paddr[2] == RegBoxHeight);
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == RegBoxHeight) ? 32'(height_q) : '0;

  assign h_eff  = (height_q == '0) ? HeightBits'(1) : height_q;
  assign hh     = h_eff >> 1;
  assign z_load = ZW'(pz_q) - ZW'(signed'({1'b0, hh}));
  assign div_n  = (NW'(pos_z_i) <<< 1) - NW'(signed'({1'b0, h_eff}));

  assign cap_ok = (count_q < CW'(MAX_BOXES));
  assign id_ok  = (32'(box_id_i) < 32'(count_q));

  assign div_start  = in_acc && (action_i == ActLoad) && cap_ok;
  assign scan_start = in_acc && (action_i == ActNearest);

  // entry word: {x, y, z, level, visible}
  assign rd_x   = mem_rdata[EW-1 -: CB];
  assign rd_y   = mem_rdata[EW-1-CB -: CB];
  assign rd_lvl = signed'(mem_rdata[8:1]);
  assign rd_vis = mem_rdata[0];

  assign md_lvl  = (rd_lvl == LevelMin) ? rd_lvl : rd_lvl - 8'sd1;
  assign md_vis  = (md_lvl < 8'sd1) ? 1'b0 : rd_vis;
  assign md_prod = h_eff * md_lvl[6:0];
  assign md_z    = (md_lvl < 8'sd1) ? ZW'(FarDownUm)
                                    : signed'(ZW'(md_prod)) - ZW'(signed'({1'b0, hh}));

  assign mem_raddr = (state_q == S_SCAN) ? scan_addr : tgt_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tgt_q;
    mem_wdata = {px_q, py_q, z_load, div_lvl, 1'b1};
    if (state_q == S_DIV && div_done) begin
      mem_we    = 1'b1;
      mem_waddr = count_q[IW-1:0];
    end else if (state_q == S_MOD) begin
      mem_we = 1'b1;
      if (act_q == ActSetPos) begin
        mem_wdata = {px_q, py_q, z_load, rd_lvl, rd_vis};
      end else begin
        mem_wdata = {rd_x, rd_y, md_z, md_lvl, md_vis};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HeightReset;
    end else if (cfg_wr) begin
      height_q <= pwdata[HeightBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      tgt_q       <= '0;
      res_hit_q   <= 1'b0;
      res_lvl_q   <= '0;
      res_vis_q   <= 1'b0;
      found_q     <= 1'b0;
      eid_q       <= '0;
      lvl_q       <= '0;
      vis_q       <= 1'b0;
      ecount_q    <= '0;
    end else begin
      // S_RESP reloads the register itself when the word is taken
      if (out_valid_q && out_ready_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_hit_q <= 1'b0;
            res_lvl_q <= '0;
            res_vis_q <= 1'b0;
            tgt_q     <= '0;
            state_q   <= S_RESP;
            case (action_i)
              ActClear: begin
                count_q <= '0;
              end
              ActLoad: begin
                if (cap_ok) begin
                  state_q <= S_DIV;
                end
              end
              ActSetPos, ActMoveDown: begin
                if (id_ok) begin
                  tgt_q   <= IW'(box_id_i);
                  state_q <= S_RD;
                end
              end
              ActNearest: begin
                state_q <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            tgt_q     <= count_q[IW-1:0];
            count_q   <= count_q + 1'b1;
            res_hit_q <= 1'b1;
            res_lvl_q <= div_lvl;
            res_vis_q <= 1'b1;
            state_q   <= S_RESP;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            if (scan_have) begin
              tgt_q   <= scan_best;
              state_q <= S_RD;
            end else begin
              state_q <= S_RESP;
            end
          end
        end
        S_RD: begin
          state_q <= S_MOD;
        end
        S_MOD: begin
          res_hit_q <= 1'b1;
          if (act_q == ActSetPos) begin
            res_lvl_q <= rd_lvl;
            res_vis_q <= rd_vis;
          end else begin
            res_lvl_q <= md_lvl;
            res_vis_q <= md_vis;
          end
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            found_q     <= res_hit_q;
            eid_q       <= 8'(tgt_q);
            lvl_q       <= res_lvl_q;
            vis_q       <= res_vis_q;
            ecount_q    <= 9'(count_q);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= action_e'(action_i);
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
      pz_q  <= pos_z_i;
    end
  end

  nbst_mem #(
    .DEPTH (MAX_BOXES),
    .WIDTH (EW),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  nbst_level_div #(
    .NW (NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     ({h_eff, 1'b0}),
    .done_o  (div_done),
    .level_o (div_lvl)
  );

  // query point comes from the captured word, the input may move on
  nbst_scan #(
    .CB (CB),
    .ZW (ZW),
    .IW (IW),
    .CW (CW),
    .EW (EW)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .count_i (count_q),
    .px_i    (px_q),
    .py_i    (py_q),
    .pz_i    (pz_q),
    .rdata_i (mem_rdata),
    .raddr_o (scan_addr),
    .done_o  (scan_done),
    .have_o  (scan_have),
    .best_o  (scan_best)
  );

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign entry_id_o    = eid_q;
  assign new_level_o   = lvl_q;
  assign now_visible_o = vis_q;
  assign entry_count_o = ecount_q;

endmodule

/* rtl/nbst_mem.sv */
// ----------------------------------------------------------------------------
// nbst_mem
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nbst_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 85,
  parameter int AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/nbst_level_div.sv */
// ----------------------------------------------------------------------------
// nbst_level_div
// Stack level of a box top: ceil(n / d) saturated to a signed byte,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nbst_level_div import nbst_pkg::*; #(
  parameter int NW = 27
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] n_i,
  input  logic [HeightBits:0]  d_i,
  output logic                 done_o,
  output logic signed [7:0]    level_o
);

  localparam int AW = (NW > 30) ? NW : 30;

  logic          busy_q, fin_q, neg_q, sat_q;
  logic [2:0]    k_q;
  logic [AW-1:0] rem_q, dvs_q;
  logic [7:0]    quo_q;

  logic [AW-1:0] mag, trial;
  logic [8:0]    q_up;

  assign mag   = AW'(n_i < 0 ? -n_i : n_i);
  assign trial = dvs_q << k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      k_q    <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= 3'd7;
      end else if (busy_q) begin
        k_q <= k_q - 3'd1;
        if (k_q == 3'd0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= mag;
      dvs_q <= AW'(d_i);
      neg_q <= (n_i < 0);
      sat_q <= (mag >= (AW'(d_i) << 8));
      quo_q <= '0;
    end else if (busy_q && rem_q >= trial) begin
      rem_q      <= rem_q - trial;
      quo_q[k_q] <= 1'b1;
    end
  end

  // positive side rounds up on a remainder, negative side truncates
  assign q_up = {1'b0, quo_q} + 9'(rem_q != '0);

  always_comb begin
    if (neg_q) begin
      level_o = (sat_q || quo_q > 8'd128) ? LevelMin : 8'(-quo_q);
    end else begin
      level_o = (sat_q || q_up > 9'd127) ? LevelMax : signed'(q_up[7:0]);
    end
  end

  assign done_o = fin_q;

endmodule

/* rtl/nbst_scan.sv */
// ----------------------------------------------------------------------------
// nbst_scan
// Nearest visible entry: walks the memory one entry a cycle through a
// diff / square / sum / compare pipeline.
// ----------------------------------------------------------------------------
module nbst_scan #(
  parameter int CB = 24,
  parameter int ZW = 28,
  parameter int IW = 8,
  parameter int CW = 9,
  parameter int EW = 85
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [CW-1:0]        count_i,
  input  logic signed [CB-1:0] px_i,
  input  logic signed [CB-1:0] py_i,
  input  logic signed [CB-1:0] pz_i,
  input  logic [EW-1:0]        rdata_i,
  output logic [IW-1:0]        raddr_o,
  output logic                 done_o,
  output logic                 have_o,
  output logic [IW-1:0]        best_o
);

  localparam int SW = 2*ZW + 2;

  logic                 active_q, iss;
  logic [CW-1:0]        addr_q, cnt_q;
  logic                 v1_q, v2_q, v3_q, v4_q;
  logic [IW-1:0]        i1_q, i2_q, i3_q, i4_q;
  logic [ZW-1:0]        ax_q, ay_q, az_q;
  logic [2*ZW-1:0]      sx_q, sy_q, sz_q;
  logic [SW-1:0]        sum_q, bsum_q;
  logic                 have_q;
  logic [IW-1:0]        best_q;

  logic signed [CB-1:0] ex, ey;
  logic signed [ZW-1:0] ez;
  logic signed [ZW:0]   dx, dy, dz;

  assign iss     = active_q && (addr_q < cnt_q);
  assign raddr_o = addr_q[IW-1:0];
  assign done_o  = active_q && !iss && !v1_q && !v2_q && !v3_q && !v4_q;

  assign ex = signed'(rdata_i[EW-1 -: CB]);
  assign ey = signed'(rdata_i[EW-1-CB -: CB]);
  assign ez = signed'(rdata_i[ZW+8:9]);
  assign dx = (ZW+1)'(ex) - (ZW+1)'(px_i);
  assign dy = (ZW+1)'(ey) - (ZW+1)'(py_i);
  assign dz = (ZW+1)'(ez) - (ZW+1)'(pz_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      addr_q   <= '0;
      cnt_q    <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      have_q   <= 1'b0;
    end else begin
      v1_q <= iss;
      v2_q <= v1_q && rdata_i[0];
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (start_i) begin
        active_q <= 1'b1;
        addr_q   <= '0;
        cnt_q    <= count_i;
        have_q   <= 1'b0;
      end else begin
        if (iss) begin
          addr_q <= addr_q + 1'b1;
        end
        if (done_o) begin
          active_q <= 1'b0;
        end
        // strict compare: the lower index keeps a tie
        if (v4_q && (!have_q || sum_q < bsum_q)) begin
          have_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q <= addr_q[IW-1:0];
    i2_q <= i1_q;
    i3_q <= i2_q;
    i4_q <= i3_q;
    ax_q <= ZW'(dx < 0 ? -dx : dx);
    ay_q <= ZW'(dy < 0 ? -dy : dy);
    az_q <= ZW'(dz < 0 ? -dz : dz);
    sx_q <= ax_q * ax_q;
    sy_q <= ay_q * ay_q;
    sz_q <= az_q * az_q;
    sum_q <= SW'(sx_q) + SW'(sy_q) + SW'(sz_q);
    if (v4_q && (!have_q || sum_q < bsum_q)) begin
      bsum_q <= sum_q;
      best_q <= i4_q;
    end
  end

  assign have_o = have_q;
  assign best_o = best_q;

endmodule

/* rtl/nbst_checker.sv */
// ----------------------------------------------------------------------------
// nbst_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module nbst_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              found_o,
  input logic [7:0]        entry_id_o,
  input logic signed [7:0] new_level_o,
  input logic              now_visible_o
);

  // a pending result word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(entry_id_o) && $stable(found_o))
    else $error("result word dropped or changed while stalled");

  // a miss reports an empty entry
  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> entry_id_o == 8'd0 && new_level_o == 8'sd0 && !now_visible_o)
    else $error("miss result carries entry data");

  // a box only goes invisible by falling below level one
  a_invis_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o && !now_visible_o |-> new_level_o < 8'sd1)
    else $error("invisible entry with positive level");

  // one word in, one word out: no new result the cycle after accepting
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared without processing");

endmodule

bind nearest_box_stack_table nbst_checker u_nbst_checker (.*);

/* verif/nearest_box_stack_table_tb.sv */
// ----------------------------------------------------------------------------
// nearest_box_stack_table_tb
// Drives load, edit, move-down and nearest-search words into the box table
// under several box heights and handshake stall patterns. Every result word
// is compared field by field against a behavioral copy of the table.
// ----------------------------------------------------------------------------
module nearest_box_stack_table_tb import nbst_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBOX = 256;
  localparam longint FarDown = -64'sd100000000;
  localparam int CycleLimit = 3000000;

  typedef struct packed {
    logic             found;
    logic [7:0]       entry_id;
    logic signed [7:0] new_level;
    logic             now_visible;
    logic [8:0]       entry_count;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] action_i = '0;
  logic [7:0] box_id_i = '0;
  logic signed [23:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic found_o, now_visible_o;
  logic [7:0] entry_id_o;
  logic signed [7:0] new_level_o;
  logic [8:0] entry_count_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  nearest_box_stack_table dut (.*);

  always #2 clk_i = ~clk_i;

  // shadow copy of the table
  longint box_x [NBOX];
  longint box_y [NBOX];
  longint box_z [NBOX];
  int     box_level [NBOX];
  bit     box_vis [NBOX];
  int     boxes_held;
  longint height_um;

  table_result_t pending_results[$];
  int  error_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  longint cycle_count = 0;

  function automatic longint eff_height();
    return (height_um == 0) ? 1 : height_um;
  endfunction

  function automatic int top_to_level(longint z);
    longint h, n, d, q;
    h = eff_height();
    n = 2 * z - h;
    d = 2 * h;
    q = (n >= 0) ? (n + d - 1) / d : -((-n) / d);
    if (q > 127) q = 127;
    if (q < -128) q = -128;
    return int'(q);
  endfunction

  function automatic void lower_box(int i);
    if (box_level[i] > -128) box_level[i]--;
    if (box_level[i] < 1) begin
      box_vis[i] = 1'b0;
      box_z[i] = FarDown;
    end else begin
      box_z[i] = eff_height() * box_level[i] - eff_height() / 2;
    end
  endfunction

  function automatic table_result_t apply_word(action_e act, int id,
                                               longint px, longint py, longint pz);
    table_result_t r;
    int hit_idx;
    bit hit;
    logic [127:0] best_d, sq_dist;
    longint dx, dy, dz;
    hit = 1'b0;
    hit_idx = 0;
    best_d = '0;
    case (act)
      ActClear: boxes_held = 0;
      ActLoad: begin
        if (boxes_held < NBOX) begin
          hit_idx = boxes_held;
          box_x[hit_idx] = px;
          box_y[hit_idx] = py;
          box_z[hit_idx] = pz - eff_height() / 2;
          box_level[hit_idx] = top_to_level(pz);
          box_vis[hit_idx] = 1'b1;
          boxes_held++;
          hit = 1'b1;
        end
      end
      ActSetPos, ActMoveDown: begin
        if (id < boxes_held) begin
          hit_idx = id;
          hit = 1'b1;
          if (act == ActSetPos) begin
            box_x[id] = px;
            box_y[id] = py;
            box_z[id] = pz - eff_height() / 2;
          end else begin
            lower_box(id);
          end
        end
      end
      ActNearest: begin
        for (int i = 0; i < boxes_held; i++) begin
          if (box_vis[i]) begin
            dx = box_x[i] - px;
            dy = box_y[i] - py;
            dz = box_z[i] - pz;
            sq_dist = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
            if (!hit || sq_dist < best_d) begin
              hit = 1'b1;
              hit_idx = i;
              best_d = sq_dist;
            end
          end
        end
        if (hit) lower_box(hit_idx);
      end
      default: ;
    endcase
    r.found = hit;
    r.entry_id = hit ? 8'(hit_idx) : '0;
    r.new_level = hit ? 8'(box_level[hit_idx]) : '0;
    r.now_visible = hit ? box_vis[hit_idx] : 1'b0;
    r.entry_count = 9'(boxes_held);
    return r;
  endfunction

  // one input word; expectation is queued at acceptance. valid stays up
  // after acceptance unless the sender idles or drains.
  task automatic send_word(logic [2:0] act, logic [7:0] id,
                           logic signed [23:0] x, logic signed [23:0] y,
                           logic signed [23:0] z);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    box_id_i <= id;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results = {pending_results, apply_word(action_e'(act), id, x, y, z)};
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_height(logic [31:0] val);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= '0;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    height_um = val & 32'hFFFFF;
  endtask

  // receiver side and result check
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (found_o !== want.found) begin
            $error("found: expected %0d actual %0d", want.found, found_o);
            error_count++;
          end
          if (entry_id_o !== want.entry_id) begin
            $error("entry_id: expected %0d actual %0d", want.entry_id, entry_id_o);
            error_count++;
          end
          if (new_level_o !== want.new_level) begin
            $error("new_level: expected %0d actual %0d", want.new_level, new_level_o);
            error_count++;
          end
          if (now_visible_o !== want.now_visible) begin
            $error("now_visible: expected %0d actual %0d", want.now_visible,
                   now_visible_o);
            error_count++;
          end
          if (entry_count_o !== want.entry_count) begin
            $error("entry_count: expected %0d actual %0d", want.entry_count,
                   entry_count_o);
            error_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'sd8388607 - 24'($urandom_range(3));
      2: return -24'sd8388608 + 24'($urandom_range(3));
      default: return 24'(int'($urandom_range(400000)) - 200000);
    endcase
  endfunction

  task automatic test_directed();
    send_word(ActNearest, 0, 0, 0, 0);            // empty table
    send_word(ActMoveDown, 0, 0, 0, 0);           // id beyond count
    send_word(ActLoad, 0, 24'sd8388607, -24'sd8388608, 24'sd8388607);
    send_word(ActLoad, 0, -24'sd8388608, 24'sd8388607, -24'sd8388608);
    send_word(ActLoad, 0, 0, 0, 24'sd57150);
    send_word(ActLoad, 0, 0, 0, 24'sd19050);      // half-height boundary
    send_word(ActLoad, 0, 0, 0, 0);               // top at zero: level zero
    send_word(ActSetPos, 8'd4, 0, 0, 24'sd57150); // tie with entry 2
    send_word(ActNearest, 0, 0, 0, 24'sd40000);
    send_word(ActMoveDown, 8'd0, 0, 0, 0);
    send_word(ActMoveDown, 8'd1, 0, 0, 0);        // already at floor
    send_word(ActMoveDown, 8'd255, 0, 0, 0);
    send_word(3'd5, 0, 0, 0, 0);
    send_word(3'd7, 8'hFF, '1, '1, '1);
    send_word(ActClear, 0, 0, 0, 0);
    send_word(ActNearest, 0, 0, 0, 0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < NBOX + 2; i++)
      send_word(ActLoad, 8'($urandom), rand_coord(), rand_coord(), rand_coord());
    send_word(ActMoveDown, 8'd255, 0, 0, 0);
    send_word(ActNearest, 0, 0, 0, 0);
    send_word(ActClear, 0, 0, 0, 0);
  endtask

  task automatic test_random(int n);
    logic [2:0] act;
    int held;
    for (int i = 0; i < n; i++) begin
      held = boxes_held;
      case ($urandom_range(19))
        0: act = ActClear;
        1, 2, 3, 4, 5: act = ActLoad;
        6, 7: act = ActSetPos;
        8, 9, 10, 11: act = ActMoveDown;
        12, 13, 14, 15, 16, 17: act = ActNearest;
        default: act = 3'($urandom_range(5, 7));
      endcase
      if (act == ActClear && held < 10 && $urandom_range(3) != 0) act = ActLoad;
      send_word(act,
                (held > 0 && $urandom_range(7) != 0) ? 8'($urandom_range(held - 1))
                                                     : 8'($urandom),
                rand_coord(), rand_coord(),
                ($urandom_range(1)) ? 24'($urandom_range(400000)) : rand_coord());
    end
  endtask

  task automatic test_sender_pause();
    send_word(ActLoad, 0, 0, 0, 24'sd100000);
    drain();
    send_word(ActNearest, 0, 0, 0, 0);
  endtask

  initial begin
    boxes_held = 0;
    height_um = HeightReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    write_height(32'd1);
    test_random(200);
    write_height(32'd0);                            // zero height acts as one
    send_idle_pct = 78;
    test_random(200);
    test_sender_pause();
    write_height(32'hFFFFF);
    send_idle_pct = 0;
    recv_stall_pct = 78;
    test_random(250);
    write_height(32'd1000000);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    test_random(250);
    write_height(32'd38100);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(250);
    write_height(32'hAAAAA);
    test_random(150);
    write_height(32'h55555);
    test_random(150);
    drain();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/nbst_pkg.sv
rtl/nbst_mem.sv
rtl/nbst_level_div.sv
rtl/nbst_scan.sv
rtl/nearest_box_stack_table.sv
rtl/nbst_checker.sv
verif/nearest_box_stack_table_tb.sv
